// ----- rtl/address_blocklist_table_assert.svh -----
// Assertion macros used by the blocklist table checker.
`ifndef ADDRESS_BLOCKLIST_TABLE_ASSERT_SVH
`define ADDRESS_BLOCKLIST_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("blocklist table check failed");

// The consequent must hold in the cycle after the antecedent.
`define ABT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("blocklist table check failed");

`endif

// ----- rtl/abt_pkg.sv -----
// Shared constants and types of the address blocklist table.
package abt_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned AddrW = 32;

  // Command codes carried on the input transfer.
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdInsert = 1'b1;

  // Status returned by the search engine to the controller.
  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

endpackage

// ----- rtl/address_blocklist_table.sv -----
// Top level of the address blocklist table: controller, write slot and result register.
//
// The table holds up to TableDepth blocked IPv4 addresses in one synchronous RAM.
// Every transfer (look up or insert) is served by a scan that reads the filled
// entries one a cycle through the RAM's single read port. N is the number of
// filled entries: the write slot before the first wrap, TableDepth after it.
// An item passes through capture, the N reads, the compare of the last read,
// a finish step and the hand-over of the result to the output register; with
// an empty table there is nothing to read or compare. The next item is taken
// in while the result sits in the output register. If that register is still
// stalled when a new result is ready, the block holds the new result and takes
// no input until the register frees. Entries are filled in order from slot zero
// and never cleared, so the write slot and a full flag stand in for per-entry
// valid bits. Reset clears both at once and needs no clearing pass.
// An insert of an address already present reports blocked and changes nothing;
// a new insert is written at the write slot, which wraps so that the oldest entry
// is overwritten once the table is full, and overwrote_oldest then reads one.
module address_blocklist_table #(
  parameter int unsigned TableDepth = abt_pkg::TableDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [abt_pkg::AddrW-1:0] ip_address_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      blocked_o,
  output logic                      added_o,
  output logic                      overwrote_oldest_o
);
  import abt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StResult = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic             full_q, full_d;
  logic             cmd_q;
  logic [AddrW-1:0] addr_q;

  // Result waiting for the output register.
  logic res_blocked_q, res_added_q, res_over_q;
  logic res_blocked_d, res_added_d, res_over_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic blocked_q, added_q, over_q;

  logic             in_xfer;
  logic             out_free;
  logic             load_out;
  logic             wr_en;
  logic [CntW-1:0]  count;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [AddrW-1:0] rd_data;
  srch_rsp_t        srch_rsp;

  assign in_xfer  = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == StResult) && out_free;
  assign count    = full_q ? CntW'(TableDepth) : CntW'(slot_q);

  // A new insert is written as the scan finishes without a hit.
  assign wr_en = (state_q == StScan) && srch_rsp.done && (cmd_q == CmdInsert) && !srch_rsp.hit;

  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    full_d        = full_q;
    res_blocked_d = res_blocked_q;
    res_added_d   = res_added_q;
    res_over_d    = res_over_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (srch_rsp.done) begin
          res_blocked_d = srch_rsp.hit;
          res_added_d   = wr_en;
          res_over_d    = wr_en && full_q;
          if (wr_en) begin
            if (slot_q == IdxW'(TableDepth - 1)) begin
              slot_d = '0;
              full_d = 1'b1;
            end else begin
              slot_d = slot_q + IdxW'(1);
            end
          end
          state_d = StResult;
        end
      end
      StResult: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= cmd_i;
      addr_q <= ip_address_i;
    end
    res_blocked_q <= res_blocked_d;
    res_added_q   <= res_added_d;
    res_over_q    <= res_over_d;
    if (load_out) begin
      blocked_q <= res_blocked_q;
      added_q   <= res_added_q;
      over_q    <= res_over_q;
    end
  end

  abt_search #(
    .TableDepth(TableDepth)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xfer),
    .count_i  (count),
    .key_i    (addr_q),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .rsp_o    (srch_rsp)
  );

  abt_ram #(
    .Width(AddrW),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(slot_q),
    .wdata_i(addr_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign in_stall_o         = (state_q != StIdle);
  assign out_valid_o        = out_valid_q;
  assign blocked_o          = blocked_q;
  assign added_o            = added_q;
  assign overwrote_oldest_o = over_q;

endmodule

// ----- rtl/abt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module abt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/abt_search.sv -----
// Sequential search engine: reads the filled entries one a cycle and compares.
module abt_search #(
  parameter int unsigned TableDepth = abt_pkg::TableDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [$clog2(TableDepth+1)-1:0] count_i,
  input  logic [abt_pkg::AddrW-1:0]       key_i,
  output logic                            rd_en_o,
  output logic [$clog2(TableDepth)-1:0]   rd_addr_o,
  input  logic [abt_pkg::AddrW-1:0]       rd_data_i,
  output abt_pkg::srch_rsp_t              rsp_o
);
  import abt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  logic            active_q, active_d;
  logic            pend_q;
  logic            hit_q, hit_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            issue;
  logic            done;

  assign issue = active_q && (idx_q < cnt_q);
  assign done  = active_q && !issue && !pend_q;

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    if (start_i) begin
      active_d = 1'b1;
      idx_d    = '0;
      cnt_d    = count_i;
      hit_d    = 1'b0;
    end else begin
      if (issue) begin
        idx_d = idx_q + CntW'(1);
      end
      // Data read in the previous cycle is compared now.
      if (pend_q && (rd_data_i == key_i)) begin
        hit_d = 1'b1;
      end
      if (done) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      pend_q   <= issue && !start_i;
      hit_q    <= hit_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
    end
  end

  assign rd_en_o    = issue;
  assign rd_addr_o  = idx_q[IdxW-1:0];
  assign rsp_o.done = done;
  assign rsp_o.hit  = hit_q;

endmodule

// ----- rtl/abt_checker.sv -----
// Port-level checker of the address blocklist table and its bind.
`include "address_blocklist_table_assert.svh"

module abt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic blocked_o,
  input logic added_o,
  input logic overwrote_oldest_o
);

  // A result never claims both a match and a new entry.
  `ABT_ASSERT_SAME(a_blocked_xor_added, out_valid_o, !(blocked_o && added_o))

  // Overwriting the oldest entry only happens on an insert that wrote one.
  `ABT_ASSERT_SAME(a_over_needs_add, out_valid_o && overwrote_oldest_o, added_o)

  // An accepted item keeps the block busy for at least the following cycle.
  `ABT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A stalled result stays, and its blocked and added fields do not change.
  `ABT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(blocked_o) && $stable(added_o))

endmodule

bind address_blocklist_table abt_checker u_abt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .blocked_o         (blocked_o),
  .added_o           (added_o),
  .overwrote_oldest_o(overwrote_oldest_o)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the address blocklist table: directed rows, then random traffic.
`timescale 1ns / 100ps

module tb_top;

  import abt_pkg::*;

  localparam int unsigned TableDepth = TableDepthDefault;
  localparam int unsigned RandomItems = 1380;
  // The last stretch of the run has no idling on either side.
  localparam int unsigned QuietItems = 150;
  // One scan of a full table plus its fixed overhead, with a margin.
  localparam int unsigned DrainCycles = 2 * TableDepth + 16;

  // What one result transfer carries, in port order.
  typedef struct packed {
    logic blocked;
    logic added;
    logic overwrote_oldest;
  } verdict_t;

  localparam verdict_t NoMatch = 3'b000;
  localparam verdict_t Match   = 3'b100;
  localparam verdict_t Stored  = 3'b010;

  // One row of the directed part. Where 'typed' is set, 'want' is the
  // expected result; otherwise the shadow table decides.
  typedef struct packed {
    logic             cmd;
    logic [AddrW-1:0] addr;
    logic             typed;
    verdict_t         want;
  } stim_row_t;

  localparam int unsigned NumDirected = 20;

  stim_row_t directed_rows [NumDirected] = '{
    // Nothing is stored yet, so both extremes miss.
    '{CmdLookup, 32'h0000_0000, 1'b1, NoMatch},
    '{CmdLookup, 32'hFFFF_FFFF, 1'b1, NoMatch},
    // The first two inserts land in empty slots.
    '{CmdInsert, 32'h0000_0000, 1'b1, Stored},
    '{CmdInsert, 32'hFFFF_FFFF, 1'b1, Stored},
    '{CmdLookup, 32'h0000_0000, 1'b1, Match},
    '{CmdLookup, 32'hFFFF_FFFF, 1'b1, Match},
    // Inserting an address already held reports it as blocked and stores nothing.
    '{CmdInsert, 32'h0000_0000, 1'b1, Match},
    '{CmdInsert, 32'hFFFF_FFFF, 1'b1, Match},
    // Single-bit neighbours of the stored all-zero address must not match.
    '{CmdLookup, 32'h8000_0000, 1'b1, NoMatch},
    '{CmdLookup, 32'h0000_0001, 1'b1, NoMatch},
    '{CmdInsert, 32'h0000_0001, 1'b1, Stored},
    '{CmdInsert, 32'h8000_0000, 1'b1, Stored},
    '{CmdInsert, 32'hAAAA_AAAA, 1'b0, NoMatch},
    '{CmdInsert, 32'h5555_5555, 1'b0, NoMatch},
    '{CmdLookup, 32'h5555_5554, 1'b0, NoMatch},
    '{CmdLookup, 32'hAAAA_AAAA, 1'b0, NoMatch},
    '{CmdInsert, 32'hC0A8_0001, 1'b0, NoMatch},
    '{CmdInsert, 32'h0A00_0001, 1'b0, NoMatch},
    '{CmdInsert, 32'hC0A8_0001, 1'b0, NoMatch},
    '{CmdLookup, 32'h7FFF_FFFF, 1'b0, NoMatch}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             cmd_i;
  logic [AddrW-1:0] ip_address_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             blocked_o;
  logic             added_o;
  logic             overwrote_oldest_o;

  // Shadow copy of the table, updated as each input transfer is accepted.
  logic [AddrW-1:0] shadow_addr  [TableDepth];
  logic             shadow_valid [TableDepth];
  int unsigned      shadow_slot;

  verdict_t         pending_verdicts [$];
  logic [AddrW-1:0] inserted_history [$];

  // Idling odds: zero means none, otherwise one chance in that many.
  int unsigned in_gap_odds;
  int unsigned out_stall_odds;

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned inserts_sent;
  int unsigned results_checked;
  int unsigned evictions;
  int unsigned wraps;

  address_blocklist_table #(
    .TableDepth(TableDepth)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .ip_address_i      (ip_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .blocked_o         (blocked_o),
    .added_o           (added_o),
    .overwrote_oldest_o(overwrote_oldest_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A fixed ceiling on the run, several times the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns, result %0d: %s", $time, results_checked, what);
    mismatches++;
  endtask

  // Works out the result of one item against the shadow table and applies
  // any insert to it. Every valid entry is searched, also after a wrap.
  function automatic verdict_t blocklist_verdict(input logic cmd, input logic [AddrW-1:0] addr);
    verdict_t v;
    logic     hit;
    v   = NoMatch;
    hit = 1'b0;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      if (shadow_valid[i] && shadow_addr[i] == addr) begin
        hit = 1'b1;
      end
    end
    v.blocked = hit;
    if (cmd == CmdInsert && !hit) begin
      v.added            = 1'b1;
      v.overwrote_oldest = shadow_valid[shadow_slot];
      shadow_addr[shadow_slot]  = addr;
      shadow_valid[shadow_slot] = 1'b1;
      if (shadow_slot == TableDepth - 1) begin
        shadow_slot = 0;
        wraps++;
      end else begin
        shadow_slot++;
      end
    end
    return v;
  endfunction

  // Picks an address for the random part. Nearly half come from addresses
  // already inserted, old ones included, so that hits, duplicates and lookups
  // of evicted entries are frequent; the rest are fresh, near misses or corner patterns.
  function automatic logic [AddrW-1:0] pick_address();
    int unsigned      sel;
    int unsigned      span;
    logic [AddrW-1:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 40 || inserted_history.size() == 0) begin
      a = $urandom();
    end else if (sel < 70) begin
      a = inserted_history[$urandom_range(0, inserted_history.size() - 1)];
    end else if (sel < 86) begin
      // Recent inserts are likely still held.
      span = (inserted_history.size() < TableDepth) ? inserted_history.size() : TableDepth;
      a = inserted_history[inserted_history.size() - 1 - $urandom_range(0, span - 1)];
    end else if (sel < 94) begin
      a = inserted_history[$urandom_range(0, inserted_history.size() - 1)]
          ^ (32'h1 << $urandom_range(0, AddrW - 1));
    end else begin
      case ($urandom_range(0, 3))
        0: a = '0;
        1: a = '1;
        2: a = 32'h1 << $urandom_range(0, AddrW - 1);
        default: a = ~(32'h1 << $urandom_range(0, AddrW - 1));
      endcase
    end
    return a;
  endfunction

  // Offers one item, holds it until the transfer takes place, then records
  // the expected result. Inputs only change on the falling edge.
  task automatic send_transfer(input logic cmd, input logic [AddrW-1:0] addr,
                               input logic typed, input verdict_t want);
    verdict_t predicted;
    if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    ip_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    predicted = blocklist_verdict(cmd, addr);
    pending_verdicts.push_back(typed ? want : predicted);
    if (predicted.overwrote_oldest) begin
      evictions++;
    end
    if (cmd == CmdInsert) begin
      inserts_sent++;
      inserted_history.push_back(addr);
      if (inserted_history.size() > 4 * TableDepth) begin
        void'(inserted_history.pop_front());
      end
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Output side: stalls come in bursts whose odds the stimulus process
  // changes from one stretch of items to the next.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every result transfer is checked, field by field, against the oldest
  // expectation still waiting.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result transfer with no item outstanding");
      end else begin
        if (blocked_o !== pending_verdicts[0].blocked) begin
          report_mismatch($sformatf("blocked is %b, expected %b",
                                    blocked_o, pending_verdicts[0].blocked));
        end
        if (added_o !== pending_verdicts[0].added) begin
          report_mismatch($sformatf("added is %b, expected %b",
                                    added_o, pending_verdicts[0].added));
        end
        if (overwrote_oldest_o !== pending_verdicts[0].overwrote_oldest) begin
          report_mismatch($sformatf("overwrote_oldest is %b, expected %b",
                                    overwrote_oldest_o, pending_verdicts[0].overwrote_oldest));
        end
        void'(pending_verdicts.pop_front());
      end
      results_checked++;
    end
  end

  initial begin
    logic             cmd;
    logic [AddrW-1:0] addr;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CmdLookup;
    ip_address_i   = '0;
    in_gap_odds    = 3;
    out_stall_odds = 4;
    mismatches      = 0;
    items_sent      = 0;
    inserts_sent    = 0;
    results_checked = 0;
    evictions       = 0;
    wraps           = 0;
    shadow_slot     = 0;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      shadow_addr[i]  = '0;
      shadow_valid[i] = 1'b0;
    end

    // Reset is held low at the start and released on a falling edge, away from the rising edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, extremes, duplicates and near misses.
    foreach (directed_rows[r]) begin
      send_transfer(directed_rows[r].cmd, directed_rows[r].addr,
                    directed_rows[r].typed, directed_rows[r].want);
    end

    // Random part. Roughly half the items are inserts, mostly of fresh
    // addresses, so the write slot wraps several times and the oldest
    // entries are overwritten. Idling changes every hundred items and
    // stops altogether for the final stretch.
    for (int unsigned k = 0; k < RandomItems; k++) begin
      if (k >= RandomItems - QuietItems) begin
        in_gap_odds    = 0;
        out_stall_odds = 0;
      end else if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: in_gap_odds = 0;
          1: in_gap_odds = 3;
          default: in_gap_odds = 12;
        endcase
        case ($urandom_range(0, 2))
          0: out_stall_odds = 0;
          1: out_stall_odds = 4;
          default: out_stall_odds = 40;
        endcase
      end
      cmd  = ($urandom_range(0, 1) == 1) ? CmdInsert : CmdLookup;
      addr = pick_address();
      send_transfer(cmd, addr, 1'b0, NoMatch);
    end
    in_valid_i <= 1'b0;

    // Let every outstanding result arrive, then watch a little longer for
    // any stray result transfer.
    while (pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_verdicts.size()));
    end

    $display("Covered %0d items (%0d inserts) and checked %0d results.",
             items_sent, inserts_sent, results_checked);
    $display("The write slot wrapped %0d times and %0d oldest entries were replaced.",
             wraps, evictions);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/abt_pkg.sv
rtl/abt_ram.sv
rtl/abt_search.sv
rtl/address_blocklist_table.sv
rtl/abt_checker.sv
sim/tb_top.sv
